// ----- rtl/bsde_pkg.sv -----
`timescale 1ns / 1ps
package bsde_pkg;

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;
   localparam int DEF_MAX_RADIUS = 31;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 11;
   localparam int RADIUS_W   = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_OP_MODE      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BORDER_MODE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 3'd4;

   localparam logic OP_DILATE = 1'b0;
   localparam logic OP_ERODE  = 1'b1;

   localparam logic FUNC_PIXEL = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_RD,
      ST_ACC,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic take;        // input beat accepted this cycle
      logic scan_init;   // load window scan from output position
      logic scan_step;   // advance window coordinates
      logic acc_en;      // fold read data into accumulator
      logic emit;        // load result register
   } cmd_type;

   typedef struct packed {
      logic emit_ok;
      logic scan_last;
      logic out_free;
   } status_type;

endpackage

// ----- rtl/bsde_ctrl.sv -----
`timescale 1ns / 1ps
module bsde_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                csr_ready,
   input  bsde_pkg::status_type status,
   output bsde_pkg::cmd_type    cmd
);
   import bsde_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      csr_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            csr_ready = 1'b1;
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (status.emit_ok) begin
               cmd.scan_init = 1'b1;
               state_in      = ST_RD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_RD: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc_en = 1'b1;
            if (status.scan_last) begin
               state_in = ST_EMIT;
            end else begin
               cmd.scan_step = 1'b1;
               state_in      = ST_RD;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/bsde_dp.sv -----
`timescale 1ns / 1ps
module bsde_dp #(
   parameter int MAX_WIDTH  = bsde_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = bsde_pkg::DEF_MAX_HEIGHT,
   parameter int MAX_RADIUS = bsde_pkg::DEF_MAX_RADIUS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_func,
   input  logic                                req_pixel_in,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [bsde_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bsde_pkg::CSR_DATA_W-1:0]     csr_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_pixel_out,
   output logic                                rsp_frame_last,
   input  bsde_pkg::cmd_type                   cmd,
   output bsde_pkg::status_type                status
);
   import bsde_pkg::*;

   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int RW = $clog2(MAX_RADIUS + 1);
   localparam int SW = ((WW > HW) ? WW : HW) + 2;
   localparam int PW = WW + HW;
   localparam int IDX_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
   localparam int STORE_USED = (2 * MAX_RADIUS + 1) * MAX_WIDTH + 2 * MAX_RADIUS + 1;
   localparam int AW = $clog2(STORE_USED);
   localparam int DEPTH = 2 ** AW;

   // configuration
   logic                  op_mode_ff;
   logic [RADIUS_W-1:0]   radius_ff;
   logic                  border_ff;
   logic [CSR_DATA_W-1:0] width_ff;
   logic [CSR_DATA_W-1:0] height_ff;
   logic                  csr_we;

   logic [WW-1:0] eff_w;
   logic [HW-1:0] eff_h;
   logic [RW-1:0] eff_r;
   logic [IDX_W-1:0] total_ff;
   logic [IDX_W-1:0] delay_ff;

   // position counters
   logic [HW-1:0]    in_row_ff, in_row_in;
   logic [WW-1:0]    in_col_ff, in_col_in;
   logic [IDX_W-1:0] in_idx_ff, in_idx_in;
   logic [HW-1:0]    out_row_ff, out_row_in;
   logic [WW-1:0]    out_col_ff, out_col_in;
   logic [IDX_W-1:0] out_idx_ff, out_idx_in;
   logic             out_last;
   logic             wr_en;

   // window scan
   logic signed [SW-1:0] sa_ff, sb_ff, end_a_ff, end_b_ff, start_b_ff;
   logic signed [SW-1:0] r_s, c_s, rad_s, h_s, w_s;
   logic                 single;
   logic [HW-1:0]        a_cl;
   logic [WW-1:0]        b_cl;
   logic [PW-1:0]        lin_addr;
   logic [AW-1:0]        rd_addr;
   logic                 rd_ff;
   logic                 acc_ff;

   logic mem [0:DEPTH-1];

   logic rsp_valid_ff, pixel_ff, last_ff;

   assign csr_we = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         op_mode_ff <= OP_DILATE;
         radius_ff  <= RADIUS_W'(2);
         border_ff  <= 1'b0;
         width_ff   <= CSR_DATA_W'(1024);
         height_ff  <= CSR_DATA_W'(768);
      end else if (csr_we) begin
         case (csr_index)
            CSR_OP_MODE:      op_mode_ff <= csr_data[0];
            CSR_RADIUS:       radius_ff  <= csr_data[RADIUS_W-1:0];
            CSR_BORDER_MODE:  border_ff  <= csr_data[0];
            CSR_FRAME_WIDTH:  width_ff   <= csr_data;
            CSR_FRAME_HEIGHT: height_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (width_ff == '0) eff_w = WW'(1);
      else if (int'(width_ff) > MAX_WIDTH) eff_w = WW'(MAX_WIDTH);
      else eff_w = WW'(width_ff);
      if (height_ff == '0) eff_h = HW'(1);
      else if (int'(height_ff) > MAX_HEIGHT) eff_h = HW'(MAX_HEIGHT);
      else eff_h = HW'(height_ff);
      if (int'(radius_ff) > MAX_RADIUS) eff_r = RW'(MAX_RADIUS);
      else eff_r = RW'(radius_ff);
   end

   // registered from the config registers; items must not arrive before these settle (not enforced)
   always_ff @(posedge clock) begin
      total_ff <= IDX_W'(PW'(eff_w) * PW'(eff_h));
      delay_ff <= IDX_W'(PW'(eff_r) * PW'(eff_w) + PW'(eff_r));
   end

   assign wr_en    = cmd.take && (req_func == FUNC_PIXEL) && (in_row_ff < eff_h);
   assign out_last = (out_idx_ff == total_ff - IDX_W'(1));

   always_comb begin
      in_row_in  = in_row_ff;
      in_col_in  = in_col_ff;
      in_idx_in  = in_idx_ff;
      out_row_in = out_row_ff;
      out_col_in = out_col_ff;
      out_idx_in = out_idx_ff;
      if (wr_en) begin
         in_idx_in = in_idx_ff + IDX_W'(1);
         if (in_col_ff + WW'(1) >= eff_w) begin
            in_col_in = '0;
            in_row_in = in_row_ff + HW'(1);
         end else begin
            in_col_in = in_col_ff + WW'(1);
         end
      end
      if (cmd.emit) begin
         out_idx_in = out_idx_ff + IDX_W'(1);
         if (out_col_ff + WW'(1) >= eff_w) begin
            out_col_in = '0;
            out_row_in = out_row_ff + HW'(1);
         end else begin
            out_col_in = out_col_ff + WW'(1);
         end
      end
      if (csr_we || (cmd.emit && out_last)) begin
         in_row_in  = '0;
         in_col_in  = '0;
         in_idx_in  = '0;
         out_row_in = '0;
         out_col_in = '0;
         out_idx_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_row_ff  <= '0;
         in_col_ff  <= '0;
         in_idx_ff  <= '0;
         out_row_ff <= '0;
         out_col_ff <= '0;
         out_idx_ff <= '0;
      end else begin
         in_row_ff  <= in_row_in;
         in_col_ff  <= in_col_in;
         in_idx_ff  <= in_idx_in;
         out_row_ff <= out_row_in;
         out_col_ff <= out_col_in;
         out_idx_ff <= out_idx_in;
      end
   end

   assign status.emit_ok = (out_idx_ff < total_ff) && (in_idx_ff >= out_idx_ff) &&
                           ((in_idx_ff - out_idx_ff > delay_ff) || (in_idx_ff == total_ff));

   assign r_s   = signed'(SW'(out_row_ff));
   assign c_s   = signed'(SW'(out_col_ff));
   assign rad_s = signed'(SW'(eff_r));
   assign h_s   = signed'(SW'(eff_h));
   assign w_s   = signed'(SW'(eff_w));

   // border mode 0 near an edge: the window shrinks to the pixel itself
   assign single = !border_ff &&
                   ((r_s < rad_s) || (c_s < rad_s) ||
                    (r_s + rad_s >= h_s) || (c_s + rad_s >= w_s));

   always_ff @(posedge clock) begin
      if (cmd.scan_init) begin
         if (single) begin
            sa_ff      <= r_s;
            sb_ff      <= c_s;
            start_b_ff <= c_s;
            end_a_ff   <= r_s;
            end_b_ff   <= c_s;
         end else begin
            sa_ff      <= r_s - rad_s;
            sb_ff      <= c_s - rad_s;
            start_b_ff <= c_s - rad_s;
            end_a_ff   <= r_s + rad_s;
            end_b_ff   <= c_s + rad_s;
         end
      end else if (cmd.scan_step) begin
         if (sb_ff == end_b_ff) begin
            sb_ff <= start_b_ff;
            sa_ff <= sa_ff + SW'(1);
         end else begin
            sb_ff <= sb_ff + SW'(1);
         end
      end
   end

   assign status.scan_last = (sa_ff == end_a_ff) && (sb_ff == end_b_ff);

   always_comb begin
      if (sa_ff[SW-1]) a_cl = '0;
      else if (sa_ff >= h_s) a_cl = HW'(h_s - SW'(1));
      else a_cl = HW'(sa_ff);
      if (sb_ff[SW-1]) b_cl = '0;
      else if (sb_ff >= w_s) b_cl = WW'(w_s - SW'(1));
      else b_cl = WW'(sb_ff);
   end

   assign lin_addr = PW'(a_cl) * PW'(eff_w) + PW'(b_cl);
   assign rd_addr  = AW'(lin_addr);

   // ring of pixels indexed by raster position modulo a power of two
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[AW'(in_idx_ff)] <= req_pixel_in;
      end
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_init) begin
         acc_ff <= op_mode_ff;
      end else if (cmd.acc_en) begin
         acc_ff <= (op_mode_ff == OP_ERODE) ? (acc_ff & rd_ff) : (acc_ff | rd_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         pixel_ff <= acc_ff;
         last_ff  <= out_last;
      end
   end

   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_out   = pixel_ff;
   assign rsp_frame_last  = last_ff;

   a_emit_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result loaded over an unsent beat");

   a_out_behind_in: assert property (@(posedge clock) disable iff (reset)
      out_idx_ff <= in_idx_ff)
      else $error("output position ahead of input position");

   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && out_last) |=> (out_idx_ff == '0) && (in_idx_ff == '0))
      else $error("counters not cleared after frame end");

endmodule

// ----- rtl/binary_square_dilate_erode_top.sv -----
`timescale 1ns / 1ps
// Binary square-window dilation/erosion over a raster pixel stream. Each pixel is
// written into a line store of single-bit entries; once enough input has arrived
// the controller scans the (2R+1)x(2R+1) window of the next output pixel through
// the store's single read port, one window pixel per RD/ACC state pair; in border
// mode 0 the window at an edge is just the pixel itself. Beats are taken only in
// IDLE; a beat that yields no result goes from DECIDE back to IDLE, one with a
// result waits in EMIT while the output stalls. Drain beats (func = 1) flush the
// last R*W+R outputs of a frame. A register write restarts the frame.
module binary_square_dilate_erode_top #(
   parameter int MAX_WIDTH  = bsde_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = bsde_pkg::DEF_MAX_HEIGHT,
   parameter int MAX_RADIUS = bsde_pkg::DEF_MAX_RADIUS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_func,
   input  logic                            req_pixel_in,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_pixel_out,
   output logic                            rsp_frame_last,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bsde_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bsde_pkg::CSR_DATA_W-1:0] csr_data
);
   import bsde_pkg::*;

   cmd_type    cmd;
   status_type status;

   bsde_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .csr_ready (csr_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bsde_dp #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .MAX_RADIUS (MAX_RADIUS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_func       (req_func),
      .req_pixel_in   (req_pixel_in),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pixel_out  (rsp_pixel_out),
      .rsp_frame_last (rsp_frame_last),
      .cmd            (cmd),
      .status         (status)
   );

endmodule
